// ----- src/srsub_pkg.sv -----
// Shared defaults for the ring-buffer sub-allocator and its checker.
package srsub_pkg;

    localparam int OFFSET_BITS_DEF = 20;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int SERIAL_BITS_DEF = 32;

endpackage

// ----- src/srsub_queue.sv -----
// Request queue memory: one write port and one registered read port.
module srsub_queue #(
    parameter int OFFSET_BITS = srsub_pkg::OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = srsub_pkg::QUEUE_DEPTH_DEF,
    parameter int SERIAL_BITS = srsub_pkg::SERIAL_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
    input  logic [SERIAL_BITS-1:0]         wr_serial,
    input  logic [OFFSET_BITS:0]           wr_end,
    input  logic [OFFSET_BITS:0]           wr_size,
    input  logic                           rd_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
    output logic [SERIAL_BITS-1:0]         rd_serial,
    output logic [OFFSET_BITS:0]           rd_end,
    output logic [OFFSET_BITS:0]           rd_size
);

    localparam int W       = OFFSET_BITS + 1;
    localparam int ENTRY_W = SERIAL_BITS + 2 * W;

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_serial, wr_end, wr_size};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_size   = rd_word_reg[W-1:0];
    assign rd_end    = rd_word_reg[2*W-1:W];
    assign rd_serial = rd_word_reg[ENTRY_W-1:2*W];

endmodule

// ----- src/serial_ring_suballocator.sv -----
// Ring-buffer sub-allocator with serial-tracked requests and in-order reclaim.
//
//   Channel   Handshake           Contents
//   s_*       s_tvalid/s_tready   tuser: action; tdata: alloc_size, pending, completed
//   m_*       m_tvalid/m_tready   tdata: ok, start_offset, used_size, queue_full, empty
//   cfg_*     cfg_wr_en           cfg_wr_data: buffer_size, taken at once
//
// An allocate beat settles the placement in the accept cycle; in ST_ALLOC, once the
// result register is free, it updates the counters and loads the result register.
// A tick may record the pending request in ST_TICK_REC, then retires requests in turn;
// each retirement is a read of the queue memory followed by a check on its registered data.
// Reset is asynchronous and takes effect at once; the queue memory needs no clearing.
// A stalled result register holds the block in its last step until the beat is taken.
module serial_ring_suballocator #(
    parameter int OFFSET_BITS = srsub_pkg::OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = srsub_pkg::QUEUE_DEPTH_DEF,
    parameter int SERIAL_BITS = srsub_pkg::SERIAL_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // alloc_size, pending_serial, completed_serial (lowest first), zero padded
    input  logic [((OFFSET_BITS+1+2*SERIAL_BITS+7)/8)*8-1:0] s_tdata,
    // action: 0 allocate, 1 tick
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // ok, start_offset, used_size, queue_full, inflight_empty (lowest first), zero padded
    output logic [((2*OFFSET_BITS+4+7)/8)*8-1:0] m_tdata,
    input  logic cfg_wr_en,
    input  logic [OFFSET_BITS:0] cfg_wr_data
);

    localparam int W       = OFFSET_BITS + 1;
    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W   = 2 * OFFSET_BITS + 4;
    localparam int OUT_PW  = ((OUT_W + 7) / 8) * 8;

    localparam logic [W-1:0]     CAP_MAX  = {1'b1, {OFFSET_BITS{1'b0}}};
    localparam logic [W+1:0]     SAT_MAX  = {2'b00, {W{1'b1}}};
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ALLOC    = 3'd1;
    localparam logic [2:0] ST_TICK_REC = 3'd2;
    localparam logic [2:0] ST_TICK_RD  = 3'd3;
    localparam logic [2:0] ST_TICK_CHK = 3'd4;
    localparam logic [2:0] ST_TICK_OUT = 3'd5;

    localparam logic [1:0] PLACE_NONE = 2'd0;
    localparam logic [1:0] PLACE_END  = 2'd1;
    localparam logic [1:0] PLACE_WRAP = 2'd2;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [W-1:0]     cap_reg, cap_next;
    logic [W-1:0]     used_start_reg, used_start_next;
    logic [W-1:0]     used_end_reg, used_end_next;
    logic [W-1:0]     used_total_reg, used_total_next;
    logic [W-1:0]     open_reg, open_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] q_tail_reg, q_tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // Payload
    logic [W-1:0]           size_reg;
    logic [SERIAL_BITS-1:0] pend_reg;
    logic [SERIAL_BITS-1:0] comp_reg;
    logic [1:0]             place_reg;
    logic [W-1:0]           waste_reg;
    logic                   full_reg;
    logic [SERIAL_BITS-1:0] last_serial_reg;
    logic                   ok_out_reg;
    logic [OFFSET_BITS-1:0] start_out_reg;
    logic [W-1:0]           used_out_reg;
    logic                   full_out_reg;
    logic                   empty_out_reg;

    logic [W-1:0]           in_size;
    logic [W:0]             end_sum;
    logic                   fit_end, fit_gap, fit_wrap, split, refuse;
    logic [1:0]             place_calc;
    logic [W-1:0]           waste_calc;
    logic                   accept, out_free, out_load;
    logic [W+1:0]           total_sum, open_sum;
    logic [W-1:0]           wrap_add;
    logic                   rec_want, rec_full, rec_do;
    logic                   rd_en;
    logic [SERIAL_BITS-1:0] rd_serial;
    logic [W-1:0]           rd_end, rd_size;
    logic                   retire;
    logic                   load_ok;
    logic [OFFSET_BITS-1:0] load_start;
    logic                   load_full;

    assign in_size  = s_tdata[W-1:0];
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Placement decision, taken in the accept cycle from the settled counters.
    always_comb
    begin
        end_sum  = {1'b0, used_end_reg} + {1'b0, in_size};
        fit_end  = end_sum <= {1'b0, cap_reg};
        fit_gap  = end_sum <= {1'b0, used_start_reg};
        fit_wrap = in_size <= used_start_reg;
        split    = used_start_reg > used_end_reg;
        refuse   = used_total_reg >= cap_reg;
        waste_calc = (used_end_reg < cap_reg) ? cap_reg - used_end_reg : '0;
        if (refuse)
        begin
            place_calc = PLACE_NONE;
        end
        else if (split)
        begin
            place_calc = fit_gap ? PLACE_END : PLACE_NONE;
        end
        else if (fit_end)
        begin
            place_calc = PLACE_END;
        end
        else if (fit_wrap)
        begin
            place_calc = PLACE_WRAP;
        end
        else
        begin
            place_calc = PLACE_NONE;
        end
    end

    // A wrap adds the wasted tail as well as the chunk.
    assign wrap_add  = (place_reg == PLACE_WRAP) ? waste_reg : '0;
    assign total_sum = {2'b00, used_total_reg} + {2'b00, wrap_add} + {2'b00, size_reg};
    assign open_sum  = {2'b00, open_reg} + {2'b00, wrap_add} + {2'b00, size_reg};

    assign rec_want = (open_reg != '0) && ((count_reg == '0) || (pend_reg > last_serial_reg));
    assign rec_full = rec_want && (count_reg == FULL_CNT);
    assign rec_do   = (state_reg == ST_TICK_REC) && rec_want && !rec_full;
    assign retire   = (state_reg == ST_TICK_CHK) && (rd_serial <= comp_reg);
    assign rd_en    = (state_reg == ST_TICK_RD) && (count_reg != '0);

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        used_start_next = used_start_reg;
        used_end_next   = used_end_reg;
        used_total_next = used_total_reg;
        open_next       = open_reg;
        head_next       = head_reg;
        q_tail_next     = q_tail_reg;
        count_next      = count_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_load        = 1'b0;
        load_ok         = 1'b1;
        load_start      = '0;
        load_full       = 1'b0;

        if (cfg_wr_en)
        begin
            cap_next = (cfg_wr_data > CAP_MAX) ? CAP_MAX : cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = s_tuser ? ST_TICK_REC : ST_ALLOC;
                end
            end
            ST_ALLOC:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_ok    = place_reg != PLACE_NONE;
                    state_next = ST_IDLE;
                    if (place_reg != PLACE_NONE)
                    begin
                        used_total_next = (total_sum > SAT_MAX) ? {W{1'b1}} : total_sum[W-1:0];
                        open_next       = (open_sum > SAT_MAX) ? {W{1'b1}} : open_sum[W-1:0];
                    end
                    if (place_reg == PLACE_END)
                    begin
                        load_start    = used_end_reg[OFFSET_BITS-1:0];
                        used_end_next = used_end_reg + size_reg;
                    end
                    else if (place_reg == PLACE_WRAP)
                    begin
                        used_end_next = size_reg;
                    end
                end
            end
            ST_TICK_REC:
            begin
                if (rec_do)
                begin
                    q_tail_next = (q_tail_reg == LAST_IDX) ? '0 : q_tail_reg + 1'b1;
                    count_next  = count_reg + 1'b1;
                    open_next   = '0;
                end
                state_next = ST_TICK_RD;
            end
            ST_TICK_RD:
            begin
                state_next = (count_reg != '0) ? ST_TICK_CHK : ST_TICK_OUT;
            end
            ST_TICK_CHK:
            begin
                if (retire)
                begin
                    used_start_next = rd_end;
                    used_total_next = (used_total_reg > rd_size) ?
                                      used_total_reg - rd_size : '0;
                    head_next       = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                    count_next      = count_reg - 1'b1;
                    state_next      = ST_TICK_RD;
                end
                else
                begin
                    state_next = ST_TICK_OUT;
                end
            end
            ST_TICK_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_full  = full_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= CAP_MAX;
            used_start_reg <= '0;
            used_end_reg   <= '0;
            used_total_reg <= '0;
            open_reg       <= '0;
            head_reg       <= '0;
            q_tail_reg     <= '0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            used_start_reg <= used_start_next;
            used_end_reg   <= used_end_next;
            used_total_reg <= used_total_next;
            open_reg       <= open_next;
            head_reg       <= head_next;
            q_tail_reg     <= q_tail_next;
            count_reg      <= count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            size_reg  <= in_size;
            pend_reg  <= s_tdata[W +: SERIAL_BITS];
            comp_reg  <= s_tdata[W + SERIAL_BITS +: SERIAL_BITS];
            place_reg <= place_calc;
            waste_reg <= waste_calc;
        end
        if (state_reg == ST_TICK_REC)
        begin
            full_reg <= rec_full;
        end
        if (rec_do)
        begin
            last_serial_reg <= pend_reg;
        end
        if (out_load)
        begin
            ok_out_reg    <= load_ok;
            start_out_reg <= load_start;
            used_out_reg  <= used_total_next;
            full_out_reg  <= load_full;
            empty_out_reg <= count_reg == '0;
        end
    end

    srsub_queue #(
        .OFFSET_BITS (OFFSET_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SERIAL_BITS (SERIAL_BITS)
    ) u_queue (
        .clk       (clk),
        .wr_en     (rec_do),
        .wr_addr   (q_tail_reg),
        .wr_serial (pend_reg),
        .wr_end    (used_end_reg),
        .wr_size   (open_reg),
        .rd_en     (rd_en),
        .rd_addr   (head_reg),
        .rd_serial (rd_serial),
        .rd_end    (rd_end),
        .rd_size   (rd_size)
    );

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_PW - OUT_W){1'b0}}, empty_out_reg, full_out_reg,
                       used_out_reg, start_out_reg, ok_out_reg};

endmodule

// ----- src/srsub_checker.sv -----
// Port-level checks for the sub-allocator, bound to its top level.
module srsub_checker #(
    parameter int OFFSET_BITS = srsub_pkg::OFFSET_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((2*OFFSET_BITS+4+7)/8)*8-1:0] m_tdata
);

    // A result beat that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A refused allocation never reports an offset.
    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[OFFSET_BITS:1] == '0)
        else $error("refused allocation carries an offset");

    // Only ticks raise the full flag, and ticks always report success.
    a_full_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2*OFFSET_BITS+2] |-> m_tdata[0])
        else $error("queue full reported on a failed beat");

    // One beat is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a beat is in progress");

endmodule

bind serial_ring_suballocator srsub_checker #(
    .OFFSET_BITS (OFFSET_BITS)
) u_srsub_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
